>>> rtl/cqam_pkg.sv
// shared types and constants of the clock quality alarm monitor
// used by cqam_event_queue and clock_quality_alarm_monitor; no dependencies
`default_nettype none

package cqam_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WARN_LEVEL = 2'd0;
    localparam logic [1:0] CFG_ALARM_LEVEL = 2'd1;
    localparam logic [1:0] CFG_WARN_HOLD = 2'd2;
    localparam logic [1:0] CFG_ALARM_HOLD = 2'd3;

    localparam logic [62:0] WARN_LEVEL_RESET = 63'd1000000;
    localparam logic [62:0] ALARM_LEVEL_RESET = 63'd10000000;

    localparam logic [19:0] NS_PER_MS = 20'd1000000;
    localparam int HOLD_NS_W = 52;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

    localparam int MAX_EVENTS = 4;

    typedef enum logic [2:0] {
        EV_SRC_RAISE = 3'd0,
        EV_SRC_CLEAR = 3'd1,
        EV_WARN_RAISE = 3'd2,
        EV_WARN_CLEAR = 3'd3,
        EV_ALARM_RAISE = 3'd4,
        EV_ALARM_CLEAR = 3'd5
    } event_code_t;

    // per-entity monitor state, one memory word
    typedef struct packed {
        logic        known;
        logic [3:0]  last_source;
        logic        warn_start_valid;
        logic [62:0] warn_start_ns;
        logic        alarm_start_valid;
        logic [62:0] alarm_start_ns;
        logic        warn_active;
        logic        alarm_on;
    } state_t;

    // all events caused by one item, handed to the event queue
    typedef struct packed {
        logic [2:0]                         entity;
        event_code_t [MAX_EVENTS-1:0]       codes;
        logic [2:0]                         count;
        logic [62:0]                        quality;
        logic [3:0]                         prev_source;
        logic [3:0]                         cur_source;
    } ev_batch_t;

endpackage

`default_nettype wire

>>> rtl/cqam_event_queue.sv
// event queue: holds the events of one item and sends them one per transfer
// depends on cqam_pkg
`default_nettype none

module cqam_event_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire cqam_pkg::ev_batch_t batch,
    output logic                     busy,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // event_entity[2:0], quality_ns[65:3], previous_source[69:66],
    // current_source[73:70], zero fill
    output logic [79:0]              m_tdata,
    // event_code
    output logic [2:0]               m_tuser,
    output logic                     m_tlast
);

    logic                busy_reg;
    logic [1:0]          idx_reg;
    cqam_pkg::ev_batch_t batch_reg;

    cqam_pkg::event_code_t code;
    logic        last;
    logic        take;
    logic [62:0] quality;
    logic [3:0]  prev_source;

    assign code = batch_reg.codes[idx_reg];
    assign last = (({1'b0, idx_reg} + 3'd1) == batch_reg.count);
    assign take = busy_reg && m_tready;

    always_comb begin
        quality = '0;
        prev_source = '0;
        case (code)
            cqam_pkg::EV_SRC_RAISE, cqam_pkg::EV_SRC_CLEAR: begin
                prev_source = batch_reg.prev_source;
            end
            cqam_pkg::EV_WARN_RAISE, cqam_pkg::EV_WARN_CLEAR,
            cqam_pkg::EV_ALARM_RAISE, cqam_pkg::EV_ALARM_CLEAR: begin
                quality = batch_reg.quality;
            end
            default: begin
                quality = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg <= '0;
        end else if (take) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            batch_reg <= batch;
        end
    end

    assign busy = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tdata = {6'b0, batch_reg.cur_source, prev_source, quality, batch_reg.entity};
    assign m_tuser = code;
    assign m_tlast = last;

endmodule

`default_nettype wire

>>> rtl/clock_quality_alarm_monitor.sv
// the first event of an item is registered through stage a, stage b and the event queue
// before it is valid on m_; stage b waits there while the event queue is busy
// one item per cycle while items cause no events; an item with events holds the event
// queue until its last event is sent, and the next item waits in stage b meanwhile
// reset: synchronous, active low; clears the pipeline, the event queue, the per-entity
// valid bits (an entity not yet written reads as all-zero state), and sets the registers to their reset values
`default_nettype none

module clock_quality_alarm_monitor #(
    parameter int ENTITY_COUNT = 5,
    parameter int SOURCE_BITS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input snapshots
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entity_index[2:0], time_ns[65:3], clk_src[69:66], clk_offset[133:70],
    // clk_uncert[197:134], zero fill
    input  wire logic [199:0] s_tdata,
    // model_present[0], offset_present[1], uncertainty_present[2]
    input  wire logic [2:0]  s_tuser,
    // events
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // event_entity[2:0], quality_ns[65:3], previous_source[69:66],
    // current_source[73:70], zero fill
    output logic [79:0]      m_tdata,
    // event_code
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    // register writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [62:0] cfg_wdata
);

    localparam int ADDR_W = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
    localparam logic [4:0] ENT_LIMIT = 5'(ENTITY_COUNT);
    localparam logic [3:0] SRC_MASK = (SOURCE_BITS >= 4) ? 4'hF : 4'((1 << SOURCE_BITS) - 1);

    // ---------------- configuration registers ----------------
    logic [62:0] warn_level_reg;
    logic [62:0] alarm_level_reg;
    logic [31:0] warn_hold_ms_reg;
    logic [31:0] alarm_hold_ms_reg;
    logic [cqam_pkg::HOLD_NS_W-1:0] warn_hold_ns_reg;
    logic [cqam_pkg::HOLD_NS_W-1:0] alarm_hold_ns_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_level_reg <= cqam_pkg::WARN_LEVEL_RESET;
            alarm_level_reg <= cqam_pkg::ALARM_LEVEL_RESET;
            warn_hold_ms_reg <= '0;
            alarm_hold_ms_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                cqam_pkg::CFG_WARN_LEVEL: warn_level_reg <= cfg_wdata;
                cqam_pkg::CFG_ALARM_LEVEL: alarm_level_reg <= cfg_wdata;
                cqam_pkg::CFG_WARN_HOLD: warn_hold_ms_reg <= cfg_wdata[31:0];
                cqam_pkg::CFG_ALARM_HOLD: alarm_hold_ms_reg <= cfg_wdata[31:0];
                default: warn_level_reg <= warn_level_reg;
            endcase
        end
    end

    // hold times in ns, a registered product of the ms registers
    always_ff @(posedge aclk) begin
        warn_hold_ns_reg <= {20'b0, warn_hold_ms_reg} * {32'b0, cqam_pkg::NS_PER_MS};
        alarm_hold_ns_reg <= {20'b0, alarm_hold_ms_reg} * {32'b0, cqam_pkg::NS_PER_MS};
    end

    // ---------------- input unpacking ----------------
    logic [2:0] s_entity;
    logic       s_in_range;
    logic       s_accept;

    assign s_entity = s_tdata[2:0];
    assign s_in_range = ({2'b00, s_entity} < ENT_LIMIT);
    assign s_accept = s_tvalid && s_tready;

    // ---------------- pipeline control ----------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic q_busy;
    logic b_go;
    logic b_free;
    logic a_go;

    // b commits (state write-back, events to the queue) only into an empty queue
    assign b_go = b_valid_reg && !q_busy;
    assign b_free = !b_valid_reg || b_go;
    assign a_go = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || b_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            // entities out of range are dropped at the input transfer
            if (s_accept) begin
                a_valid_reg <= s_in_range;
            end else if (a_go) begin
                a_valid_reg <= 1'b0;
            end
            if (a_go) begin
                b_valid_reg <= 1'b1;
            end else if (b_go) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage a: input register, quality ----------------
    logic [2:0]  a_entity_reg;
    logic [62:0] a_now_reg;
    logic        a_model_reg;
    logic [3:0]  a_src_reg;
    logic        a_off_ok_reg;
    logic [63:0] a_off_reg;
    logic        a_unc_ok_reg;
    logic [63:0] a_unc_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_entity_reg <= s_entity;
            a_now_reg <= s_tdata[65:3];
            a_model_reg <= s_tuser[0];
            a_src_reg <= s_tdata[69:66] & SRC_MASK;
            a_off_ok_reg <= s_tuser[1];
            a_off_reg <= s_tdata[133:70];
            a_unc_ok_reg <= s_tuser[2];
            a_unc_reg <= s_tdata[197:134];
        end
    end

    logic [63:0]       a_neg;
    logic [62:0]       a_mag;
    logic [62:0]       a_q;
    logic              a_usable;
    logic [3:0]        a_cur;
    logic [ADDR_W+2:0] a_ent_ext;
    logic [ADDR_W-1:0] a_addr;

    assign a_neg = ~a_off_reg + 64'd1;

    always_comb begin
        // saturated offset magnitude, absent offset counts as zero
        if (!a_off_ok_reg) begin
            a_mag = '0;
        end else if (a_off_reg == cqam_pkg::SIGN64) begin
            a_mag = cqam_pkg::MAX63;
        end else if (a_off_reg[63]) begin
            a_mag = a_neg[62:0];
        end else begin
            a_mag = a_off_reg[62:0];
        end
    end

    // no model, no uncertainty or a negative one leaves no usable quality
    assign a_usable = a_model_reg && a_unc_ok_reg && !a_unc_reg[63];
    assign a_q = !a_usable ? 63'd0 : ((a_mag > a_unc_reg[62:0]) ? a_mag : a_unc_reg[62:0]);
    assign a_cur = a_model_reg ? a_src_reg : 4'd0;
    assign a_ent_ext = {{ADDR_W{1'b0}}, a_entity_reg};
    assign a_addr = a_ent_ext[ADDR_W-1:0];

    // ---------------- state memory ----------------
    cqam_pkg::state_t  state_mem [ENTITY_COUNT];
    logic [ENTITY_COUNT-1:0] ent_vld_reg;
    cqam_pkg::state_t  mem_rd_reg;
    cqam_pkg::state_t  fwd_state_reg;
    cqam_pkg::state_t  st_next;
    logic              b_ent_vld_reg;
    logic              b_fwd_reg;
    logic [ADDR_W-1:0] b_addr_reg;

    // read on entry to stage b, write when stage b commits
    always_ff @(posedge aclk) begin
        if (b_go) begin
            state_mem[b_addr_reg] <= st_next;
        end
        if (a_go) begin
            mem_rd_reg <= state_mem[a_addr];
        end
    end

    // valid bits stand in for the reset value of the memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
            b_ent_vld_reg <= 1'b0;
            b_fwd_reg <= 1'b0;
        end else begin
            if (b_go) begin
                ent_vld_reg[b_addr_reg] <= 1'b1;
            end
            if (a_go) begin
                b_ent_vld_reg <= ent_vld_reg[a_addr];
                // a write to the same entity in the read cycle is forwarded
                b_fwd_reg <= b_go && (b_addr_reg == a_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            fwd_state_reg <= st_next;
        end
    end

    // ---------------- stage b: read-modify-write and events ----------------
    logic [2:0]  b_entity_reg;
    logic [62:0] b_now_reg;
    logic        b_model_reg;
    logic [3:0]  b_src_reg;
    logic [3:0]  b_cur_reg;
    logic        b_usable_reg;
    logic [62:0] b_q_reg;

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_addr_reg <= a_addr;
            b_entity_reg <= a_entity_reg;
            b_now_reg <= a_now_reg;
            b_model_reg <= a_model_reg;
            b_src_reg <= a_src_reg;
            b_cur_reg <= a_cur;
            b_usable_reg <= a_usable;
            b_q_reg <= a_q;
        end
    end

    cqam_pkg::state_t st;
    logic        warn_exc;
    logic        alarm_exc;
    logic [62:0] warn_start;
    logic [62:0] alarm_start;
    logic [63:0] warn_diff;
    logic [63:0] alarm_diff;
    logic        warn_held;
    logic        alarm_held;

    assign st = b_fwd_reg ? fwd_state_reg : (b_ent_vld_reg ? mem_rd_reg : '0);

    assign warn_exc = (b_q_reg >= warn_level_reg);
    assign alarm_exc = (b_q_reg >= alarm_level_reg);

    // a fresh exceedance starts now
    assign warn_start = st.warn_start_valid ? st.warn_start_ns : b_now_reg;
    assign alarm_start = st.alarm_start_valid ? st.alarm_start_ns : b_now_reg;

    // borrow out marks time going backwards, which never satisfies a hold
    assign warn_diff = {1'b0, b_now_reg} - {1'b0, warn_start};
    assign alarm_diff = {1'b0, b_now_reg} - {1'b0, alarm_start};
    assign warn_held = !warn_diff[63] && (warn_diff[62:0] >= {11'b0, warn_hold_ns_reg});
    assign alarm_held = !alarm_diff[63] && (alarm_diff[62:0] >= {11'b0, alarm_hold_ns_reg});

    cqam_pkg::ev_batch_t batch;
    logic [2:0]          n;

    always_comb begin
        st_next = st;
        n = '0;
        batch.entity = b_entity_reg;
        batch.quality = b_q_reg;
        batch.prev_source = st.last_source;
        batch.cur_source = b_cur_reg;
        for (int i = 0; i < cqam_pkg::MAX_EVENTS; i++) begin
            batch.codes[i] = cqam_pkg::EV_SRC_RAISE;
        end

        // source change pulse
        if (b_model_reg && st.known && (st.last_source != b_src_reg)) begin
            batch.codes[n[1:0]] = cqam_pkg::EV_SRC_RAISE;
            n = n + 3'd1;
            batch.codes[n[1:0]] = cqam_pkg::EV_SRC_CLEAR;
            n = n + 3'd1;
        end
        if (b_model_reg) begin
            st_next.last_source = b_src_reg;
            st_next.known = 1'b1;
        end

        if (!b_usable_reg || !warn_exc) begin
            // no usable quality or below warning: clear everything
            if (st.warn_active) begin
                batch.codes[n[1:0]] = cqam_pkg::EV_WARN_CLEAR;
                n = n + 3'd1;
            end
            if (st.alarm_on) begin
                batch.codes[n[1:0]] = cqam_pkg::EV_ALARM_CLEAR;
                n = n + 3'd1;
            end
            st_next.warn_active = 1'b0;
            st_next.alarm_on = 1'b0;
            st_next.warn_start_valid = 1'b0;
            st_next.alarm_start_valid = 1'b0;
        end else begin
            st_next.warn_start_valid = 1'b1;
            st_next.warn_start_ns = warn_start;
            if (alarm_exc) begin
                st_next.alarm_start_valid = 1'b1;
                st_next.alarm_start_ns = alarm_start;
            end else begin
                st_next.alarm_start_valid = 1'b0;
                st_next.alarm_on = 1'b0;
                if (st.alarm_on) begin
                    batch.codes[n[1:0]] = cqam_pkg::EV_ALARM_CLEAR;
                    n = n + 3'd1;
                end
            end

            if (alarm_exc && alarm_held) begin
                // alarm takes over from the warning
                if (!st.alarm_on) begin
                    batch.codes[n[1:0]] = cqam_pkg::EV_ALARM_RAISE;
                    n = n + 3'd1;
                end
                if (st.warn_active) begin
                    batch.codes[n[1:0]] = cqam_pkg::EV_WARN_CLEAR;
                    n = n + 3'd1;
                end
                st_next.alarm_on = 1'b1;
                st_next.warn_active = 1'b0;
            end else if (warn_held && !st.warn_active) begin
                batch.codes[n[1:0]] = cqam_pkg::EV_WARN_RAISE;
                n = n + 3'd1;
                st_next.warn_active = 1'b1;
            end
        end
        batch.count = n;
    end

    // ---------------- event output ----------------
    cqam_event_queue u_event_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (b_go && (batch.count != 3'd0)),
        .batch    (batch),
        .busy     (q_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_clock_quality_alarm_monitor.sv
`timescale 1ns / 1ps
// self-checking bench for clock_quality_alarm_monitor: snapshot driver, event monitor
// and a cycle-free predictor of the per-entity warning and alarm events
// depends on cqam_pkg and the clock_quality_alarm_monitor rtl

module tb_clock_quality_alarm_monitor;

    localparam int ENTITIES = 5;
    localparam int SETTLE_CYCLES = 12;   // pipeline depth plus slack for event-free items
    localparam int QUIET_LIMIT = 2000;   // cycles without any transfer before giving up

    // one clock-quality snapshot as sent on s_
    typedef struct packed {
        logic [2:0]  entity;
        logic [62:0] stamp_ns;
        logic        model;
        logic [3:0]  source;
        logic        off_ok;
        logic [63:0] offset;
        logic        unc_ok;
        logic [63:0] unc;
    } snapshot_t;

    // one raise or clear event as seen on m_
    typedef struct packed {
        logic [2:0]            entity;
        cqam_pkg::event_code_t code;
        logic [62:0]           quality;
        logic [3:0]            prev_src;
        logic [3:0]            cur_src;
        logic                  last;
    } alarm_event_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [62:0]  cfg_wdata;

    clock_quality_alarm_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the registers, loaded whenever the bench writes them
    logic [62:0] lvl_warn = cqam_pkg::WARN_LEVEL_RESET;
    logic [62:0] lvl_alarm = cqam_pkg::ALARM_LEVEL_RESET;
    logic [31:0] hold_warn_ms = '0;
    logic [31:0] hold_alarm_ms = '0;

    // predictor copy of the per-entity monitor state
    bit          seen_src    [ENTITIES];
    logic [3:0]  prev_src    [ENTITIES];
    bit          warn_armed  [ENTITIES];
    logic [62:0] warn_since  [ENTITIES];
    bit          alarm_armed [ENTITIES];
    logic [62:0] alarm_since [ENTITIES];
    bit          warn_up     [ENTITIES];
    bit          alarm_up    [ENTITIES];

    // stimulus tracking for well-formed per-entity sequences
    logic [62:0] stamp_cursor [ENTITIES];
    logic [3:0]  track_src    [ENTITIES];
    logic [62:0] track_q      [ENTITIES];

    snapshot_t    snapshot_queue[$];   // snapshots waiting for the driver
    alarm_event_t due_events[$];       // predicted events not yet seen on m_
    snapshot_t    on_wire;             // snapshot currently offered on s_

    bit took_snapshot = 1'b0;
    bit idle_on = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int mismatches = 0;
    int snapshots_sent = 0;
    int ignored_sent = 0;
    int events_seen = 0;
    int settings_used = 1;
    int code_hits[6];

    // ---------------------------------------------------------------- clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------- helpers

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly back to back, sometimes a few cycles, rarely a long pause; always back to back while idle_on is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic void note_event(int e, cqam_pkg::event_code_t code, logic [62:0] q,
                                       logic [3:0] prev, logic [3:0] cur);
        alarm_event_t ev;
        ev.entity = 3'(e);
        ev.code = code;
        ev.quality = q;
        ev.prev_src = prev;
        ev.cur_src = cur;
        ev.last = 1'b0;
        due_events.push_back(ev);
    endfunction

    // quality gone or below warning: clear whatever is raised and forget both starts
    function automatic void drop_exceedances(int e, logic [62:0] q, logic [3:0] cur);
        if (warn_up[e])
            note_event(e, cqam_pkg::EV_WARN_CLEAR, q, 4'd0, cur);
        if (alarm_up[e])
            note_event(e, cqam_pkg::EV_ALARM_CLEAR, q, 4'd0, cur);
        warn_up[e] = 1'b0;
        alarm_up[e] = 1'b0;
        warn_armed[e] = 1'b0;
        alarm_armed[e] = 1'b0;
    endfunction

    // a stamp earlier than the start never counts as held
    function automatic bit held_long_enough(logic [62:0] now, logic [62:0] since,
                                            logic [31:0] hold_ms);
        return (now >= since) &&
               ((64'(now) - 64'(since)) >= (64'(hold_ms) * 64'd1000000));
    endfunction

    // works out every event one accepted snapshot causes, in order
    function automatic void assess_snapshot(snapshot_t s);
        int          e;
        int          depth_before;
        logic [3:0]  cur;
        logic [63:0] mag;
        logic [62:0] q;
        bit          warn_exc;
        bit          alarm_exc;
        e = int'(s.entity);
        depth_before = due_events.size();
        cur = s.model ? s.source : 4'd0;
        if (e < ENTITIES) begin
            // source change shows up as a raise immediately followed by a clear
            if (s.model && seen_src[e] && prev_src[e] != s.source) begin
                note_event(e, cqam_pkg::EV_SRC_RAISE, 63'd0, prev_src[e], cur);
                note_event(e, cqam_pkg::EV_SRC_CLEAR, 63'd0, prev_src[e], cur);
            end
            if (s.model) begin
                prev_src[e] = s.source;
                seen_src[e] = 1'b1;
            end

            if (!s.model || !s.unc_ok || s.unc[63]) begin
                drop_exceedances(e, 63'd0, cur);
            end else begin
                // most negative offset saturates, absent offset counts as zero
                if (!s.off_ok)
                    mag = 64'd0;
                else if (s.offset == cqam_pkg::SIGN64)
                    mag = {1'b0, cqam_pkg::MAX63};
                else if (s.offset[63])
                    mag = -s.offset;
                else
                    mag = s.offset;
                q = (mag > s.unc) ? mag[62:0] : s.unc[62:0];
                warn_exc = (q >= lvl_warn);
                alarm_exc = (q >= lvl_alarm);

                if (!warn_exc) begin
                    drop_exceedances(e, q, cur);
                end else begin
                    if (!warn_armed[e]) begin
                        warn_armed[e] = 1'b1;
                        warn_since[e] = s.stamp_ns;
                    end
                    if (alarm_exc) begin
                        if (!alarm_armed[e]) begin
                            alarm_armed[e] = 1'b1;
                            alarm_since[e] = s.stamp_ns;
                        end
                    end else begin
                        alarm_armed[e] = 1'b0;
                        if (alarm_up[e])
                            note_event(e, cqam_pkg::EV_ALARM_CLEAR, q, 4'd0, cur);
                        alarm_up[e] = 1'b0;
                    end

                    // a held alarm takes over from the warning
                    if (alarm_exc &&
                        held_long_enough(s.stamp_ns, alarm_since[e], hold_alarm_ms)) begin
                        if (!alarm_up[e])
                            note_event(e, cqam_pkg::EV_ALARM_RAISE, q, 4'd0, cur);
                        if (warn_up[e])
                            note_event(e, cqam_pkg::EV_WARN_CLEAR, q, 4'd0, cur);
                        alarm_up[e] = 1'b1;
                        warn_up[e] = 1'b0;
                    end else if (held_long_enough(s.stamp_ns, warn_since[e], hold_warn_ms) &&
                                 !warn_up[e]) begin
                        note_event(e, cqam_pkg::EV_WARN_RAISE, q, 4'd0, cur);
                        warn_up[e] = 1'b1;
                    end
                end
            end
            if (due_events.size() > depth_before)
                due_events[due_events.size() - 1].last = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_snapshot(logic [2:0] e, logic [62:0] t, bit model,
                                           logic [3:0] src, bit off_ok, logic [63:0] off,
                                           bit unc_ok, logic [63:0] unc);
        snapshot_t s;
        s.entity = e;
        s.stamp_ns = t;
        s.model = model;
        s.source = src;
        s.off_ok = off_ok;
        s.offset = off;
        s.unc_ok = unc_ok;
        s.unc = unc;
        snapshot_queue.push_back(s);
    endfunction

    // quality values clustered on the current level edges
    function automatic logic [62:0] pick_quality();
        logic [63:0] span;
        span = 64'(lvl_alarm) - 64'(lvl_warn);
        case ($urandom_range(0, 9))
            0: return 63'd0;
            1: return lvl_warn - 63'd1;
            2: return lvl_warn;
            3: return (lvl_alarm > lvl_warn) ? lvl_warn + 63'(rand64() % span) : lvl_warn;
            4: return lvl_alarm - 63'd1;
            5: return lvl_alarm;
            6: return (lvl_alarm > cqam_pkg::MAX63 - 63'd5000)
                      ? cqam_pkg::MAX63
                      : lvl_alarm + 63'($urandom_range(0, 5000));
            7: return cqam_pkg::MAX63;
            8: return 63'(rand64());
            default: return lvl_warn >> 1;
        endcase
    endfunction

    // mostly per-entity sequences with sticky quality and stamps stepped around
    // the hold times, the rest raw noise on every field
    function automatic snapshot_t random_snapshot();
        snapshot_t   s;
        int          e;
        logic [63:0] hold_ns;
        logic [63:0] advance;
        logic [63:0] mag;
        logic [62:0] q;
        e = $urandom_range(0, ENTITIES - 1);
        if ($urandom_range(0, 99) < 75) begin
            hold_ns = 64'($urandom_range(0, 1) ? hold_warn_ms : hold_alarm_ms) * 64'd1000000;
            case ($urandom_range(0, 9))
                0: advance = 64'd0;
                1, 2: advance = 64'($urandom_range(1, 5000));
                3: advance = hold_ns;
                4: advance = (hold_ns > 0) ? hold_ns - 64'd1 : 64'd0;
                5: advance = hold_ns >> 1;
                6, 7: advance = hold_ns + 64'($urandom_range(0, 2000000));
                default: advance = rand64() % ((hold_ns << 1) + 64'd3000000);
            endcase
            // now and then the stamp steps backwards
            if ($urandom_range(0, 29) == 0 && stamp_cursor[e] > 63'd1000000)
                stamp_cursor[e] = stamp_cursor[e] - 63'($urandom_range(1, 1000000));
            else
                stamp_cursor[e] = stamp_cursor[e] + 63'(advance);
            if (stamp_cursor[e][62:61] != 2'b00)
                stamp_cursor[e] = 63'($urandom);
            if ($urandom_range(0, 9) == 0)
                track_src[e] = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 0)
                track_q[e] = pick_quality();
            q = track_q[e];

            s.entity = 3'(e);
            s.stamp_ns = stamp_cursor[e];
            s.model = ($urandom_range(0, 19) != 0);
            s.source = track_src[e];
            s.unc_ok = 1'b1;
            // quality carried by the offset, the uncertainty, or both
            case ($urandom_range(0, 2))
                0: begin
                    s.off_ok = 1'b1;
                    s.offset = $urandom_range(0, 1) ? -{1'b0, q} : {1'b0, q};
                    s.unc = {1'b0, 63'(rand64())} % ({1'b0, q} + 64'd1);
                end
                1: begin
                    s.unc = {1'b0, q};
                    s.off_ok = 1'b1;
                    mag = {1'b0, 63'(rand64())} % ({1'b0, q} + 64'd1);
                    s.offset = $urandom_range(0, 1) ? -mag : mag;
                end
                default: begin
                    s.unc = {1'b0, q};
                    s.off_ok = 1'b0;
                    s.offset = rand64();
                end
            endcase
        end else begin
            s.entity = 3'($urandom_range(0, 7));
            s.stamp_ns = ($urandom_range(0, 3) == 0) ? 63'(rand64()) : stamp_cursor[e];
            s.model = 1'($urandom_range(0, 1));
            s.source = 4'($urandom_range(0, 15));
            s.off_ok = 1'($urandom_range(0, 1));
            s.unc_ok = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: s.offset = cqam_pkg::SIGN64;
                1: s.offset = ~cqam_pkg::SIGN64;
                default: s.offset = rand64();
            endcase
            s.unc = rand64();
        end
        return s;
    endfunction

    // random snapshots until n of them reach a real entity
    task automatic queue_random(int n);
        snapshot_t s;
        int real_ones;
        real_ones = 0;
        while (real_ones < n) begin
            s = random_snapshot();
            snapshot_queue.push_back(s);
            if (s.entity < ENTITIES)
                real_ones++;
        end
    endtask

    // block drained: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (snapshot_queue.size() != 0 || s_tvalid || due_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [62:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
    endtask

    // all four registers, predictor copy updated alongside
    task automatic program_levels(logic [62:0] w, logic [62:0] a,
                                  logic [31:0] wh, logic [31:0] ah);
        write_reg(cqam_pkg::CFG_WARN_LEVEL, w);
        write_reg(cqam_pkg::CFG_ALARM_LEVEL, a);
        write_reg(cqam_pkg::CFG_WARN_HOLD, {31'd0, wh});
        write_reg(cqam_pkg::CFG_ALARM_HOLD, {31'd0, ah});
        @(negedge aclk);
        cfg_we <= 1'b0;
        lvl_warn = w;
        lvl_alarm = a;
        hold_warn_ms = wh;
        hold_alarm_ms = ah;
        settings_used++;
    endtask

    // ---------------------------------------------------------------- driver
    // offers the next queued snapshot once the previous transfer went through
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || took_snapshot)) begin
            if (send_gap > 0 || snapshot_queue.size() == 0) begin
                if (send_gap > 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end else begin
                on_wire = snapshot_queue.pop_front();
                s_tdata <= {2'b00, on_wire.unc, on_wire.offset, on_wire.source,
                            on_wire.stamp_ns, on_wire.entity};
                s_tuser <= {on_wire.unc_ok, on_wire.off_ok, on_wire.model};
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
        end
    end

    // input side: each snapshot transfer feeds the predictor
    always @(posedge aclk) begin
        took_snapshot <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            assess_snapshot(on_wire);
            snapshots_sent++;
            if (on_wire.entity >= ENTITIES)
                ignored_sent++;
        end
    end

    // ---------------------------------------------------------------- monitor
    // receiver backpressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    function automatic void check_field(string what, logic [62:0] want, logic [62:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // each event transfer against the oldest prediction
    always @(posedge aclk) begin
        alarm_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            events_seen++;
            if (due_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, got entity %0d code %0d q %0d",
                         $time, m_tdata[2:0], m_tuser, m_tdata[65:3]);
                mismatches++;
            end else begin
                want = due_events.pop_front();
                check_field("event_entity", 63'(want.entity), 63'(m_tdata[2:0]));
                check_field("event_code", 63'(want.code), 63'(m_tuser));
                check_field("quality_ns", want.quality, m_tdata[65:3]);
                check_field("previous_source", 63'(want.prev_src), 63'(m_tdata[69:66]));
                check_field("current_source", 63'(want.cur_src), 63'(m_tdata[73:70]));
                check_field("last_event", 63'(want.last), 63'(m_tlast));
                code_hits[int'(want.code)]++;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d events outstanding",
                 $time, QUIET_LIMIT, due_events.size());
        $display("tb_clock_quality_alarm_monitor: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- test sequence
    initial begin
        logic [62:0] w;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = cqam_pkg::CFG_WARN_LEVEL;
        cfg_wdata = '0;
        for (int i = 0; i < ENTITIES; i++) begin
            stamp_cursor[i] = 63'($urandom);
            track_src[i] = 4'($urandom_range(0, 15));
            track_q[i] = '0;
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed cases at reset levels (1 ms warning, 10 ms alarm, no hold)
        queue_snapshot(0, 63'd100, 1, 4'd3, 0, 64'd0, 1, 64'd0);
        queue_snapshot(0, 63'd200, 1, 4'd3, 0, 64'd0, 1, 64'd1000000);      // warning at level
        // source change plus alarm taking over the warning: four events
        queue_snapshot(0, 63'd300, 1, 4'd5, 1, -64'd10000000, 1, 64'd0);
        queue_snapshot(0, 63'd400, 0, 4'd9, 1, 64'd0, 1, 64'd50000000);     // model gone
        // most negative offset saturates
        queue_snapshot(1, 63'd500, 1, 4'd0, 1, cqam_pkg::SIGN64, 1, 64'd5);
        // negative uncertainty
        queue_snapshot(1, 63'd600, 1, 4'd0, 1, cqam_pkg::SIGN64, 1, -64'd1);
        // uncertainty absent
        queue_snapshot(1, 63'd700, 1, 4'd0, 1, ~cqam_pkg::SIGN64, 0, 64'd20000000);
        // entities past the end are ignored
        queue_snapshot(5, 63'd800, 1, 4'd2, 1, ~cqam_pkg::SIGN64, 1, ~cqam_pkg::SIGN64);
        queue_snapshot(6, 63'd800, 1, 4'd2, 1, ~cqam_pkg::SIGN64, 1, ~cqam_pkg::SIGN64);
        queue_snapshot(7, 63'd800, 1, 4'd2, 1, ~cqam_pkg::SIGN64, 1, ~cqam_pkg::SIGN64);
        // absent offset counts as zero whatever its bits
        queue_snapshot(2, 63'd900, 1, 4'd1, 0, 64'hFFFF_0000_0000_0000, 1, 64'd2000000);
        queue_snapshot(2, 63'd1000, 1, 4'd1, 1, -64'd3000000, 1, 64'd0);
        queue_snapshot(2, 63'd1100, 1, 4'd1, 1, 64'd200, 1, 64'd500);
        // top stamp, then stamps going backwards
        queue_snapshot(3, cqam_pkg::MAX63, 1, 4'd7, 1, ~cqam_pkg::SIGN64, 1, ~cqam_pkg::SIGN64);
        queue_snapshot(3, 63'd0, 1, 4'd7, 1, 64'd0, 1, 64'd20000000);
        queue_snapshot(3, 63'd10, 1, 4'd7, 0, 64'd0, 1, 64'd5000000);
        // current source forced to zero without a model, then first source and a change
        queue_snapshot(4, 63'd50, 0, 4'd9, 0, 64'd0, 1, 64'd100);
        queue_snapshot(4, 63'd60, 1, 4'd15, 1, 64'd1000000, 1, 64'd10);
        queue_snapshot(4, 63'd70, 1, 4'd0, 1, 64'd999999, 1, 64'd999999);
        queue_snapshot(0, 63'd1200, 1, 4'd5, 1, -64'd1, 1, 64'd0);
        wait_idle();

        // low levels, no hold, no idling at all
        idle_on = 1'b0;
        program_levels(63'd1000, 63'd5000, 32'd0, 32'd0);
        queue_random(35);
        wait_idle();

        // short holds so raises need persistence
        idle_on = 1'b1;
        program_levels(63'd200000, 63'd800000, 32'd2, 32'd5);
        queue_random(35);
        wait_idle();

        // smallest levels, longest holds
        idle_on = ($urandom_range(0, 3) != 0);
        program_levels(63'd1, 63'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(35);
        wait_idle();

        // largest levels: only a quality of MAX63 reaches them
        idle_on = 1'b1;
        program_levels(cqam_pkg::MAX63, cqam_pkg::MAX63, 32'd0, 32'd1);
        queue_random(35);
        wait_idle();

        // alarm level below warning level
        program_levels(63'd3000000, 63'd1000, 32'd1, 32'd3);
        queue_random(35);
        wait_idle();

        // random consistent setting
        idle_on = ($urandom_range(0, 3) != 0);
        w = 63'($urandom_range(1, 10000000));
        program_levels(w, w + 63'($urandom_range(1, 10000000)),
                       32'($urandom_range(0, 20)), 32'($urandom_range(0, 20)));
        queue_random(35);
        wait_idle();

        $display("covered %0d snapshots (%0d to entities out of range) over %0d level settings",
                 snapshots_sent, ignored_sent, settings_used);
        $display("checked %0d events: source %0d/%0d, warning %0d/%0d, alarm %0d/%0d raise/clear",
                 events_seen,
                 code_hits[cqam_pkg::EV_SRC_RAISE], code_hits[cqam_pkg::EV_SRC_CLEAR],
                 code_hits[cqam_pkg::EV_WARN_RAISE], code_hits[cqam_pkg::EV_WARN_CLEAR],
                 code_hits[cqam_pkg::EV_ALARM_RAISE], code_hits[cqam_pkg::EV_ALARM_CLEAR]);
        if (mismatches == 0 && due_events.size() == 0)
            $display("tb_clock_quality_alarm_monitor: done, clean");
        else
            $display("tb_clock_quality_alarm_monitor: done, errors");
        $finish;
    end

endmodule
